>>> rtl/core/upm_pkg.sv
// ----------------------------------------------------------------------------
// upm_pkg
// shared constants, codes and controller/datapath types for the upwind step
// ----------------------------------------------------------------------------
`default_nettype none

package upm_pkg;

  localparam int DEF_MAX_ROWS = 512;
  localparam int DEF_MAX_COLS = 512;

  localparam int PIX_W       = 16;
  localparam int FLAG_W      = 2;
  localparam int ROW_OUT_W   = 9;
  localparam int COL_OUT_W   = 9;
  localparam int SIZE_W      = 10;
  localparam int INV_W       = 16;
  localparam int TAU_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int ENTRY_W     = PIX_W + FLAG_W;
  localparam int TDATA_IN_W  = ((PIX_W + 7) / 8) * 8;
  localparam int TUSER_IN_W  = FLAG_W;
  localparam int OUT_BITS    = PIX_W + ROW_OUT_W + COL_OUT_W;
  localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int PROD_W      = PIX_W + INV_W;
  localparam int G_W         = PROD_W - 8;
  localparam int SQ_W        = 2 * G_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int RES_W       = SUM_W / 2;
  localparam int M_W         = RES_W + 1;
  localparam int SQRT_CNT_W  = $clog2(RES_W);

  localparam logic [SIZE_W-1:0] ROWS_RST = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] COLS_RST = SIZE_W'(512);
  localparam logic [INV_W-1:0]  INV_RST  = INV_W'(256);
  localparam logic [TAU_W-1:0]  TAU_RST  = TAU_W'(6554);

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU     = 3'd4;

  localparam logic [FLAG_W-1:0] FLAG_ERODE  = 2'b11;
  localparam logic [FLAG_W-1:0] FLAG_DILATE = 2'b01;

  localparam logic [1:0] JOB_MAIN       = 2'd0;
  localparam logic [1:0] JOB_DRAIN_UP   = 2'd1;
  localparam logic [1:0] JOB_DRAIN_LAST = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_RD_A, OP_RD_B, OP_CAP_B, OP_WRITE, OP_LOAD,
    OP_MUL, OP_SQ, OP_ACC, OP_SQ_INIT, OP_SQRT, OP_SCALE, OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_CAP_B, ST_WRITE, ST_LOAD, ST_MUL, ST_SQ,
    ST_ACC, ST_SQ_INIT, ST_SQRT, ST_SCALE, ST_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] job;
    logic [1:0] nb;
  } cmd_t;

  typedef struct packed {
    logic [2:0] jobs;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/upm_ctrl.sv
// ----------------------------------------------------------------------------
// upm_ctrl
// sequencer: line store reads and writes, then up to three result jobs
// ----------------------------------------------------------------------------
`default_nettype none

module upm_ctrl import upm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e                state_q, state_d;
  logic [1:0]            k_q, k_d;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]            pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.job  = JOB_MAIN;
    cmd_o.nb   = k_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = ST_RD_A;
        end
      end
      ST_RD_A: begin
        cmd_o.op = OP_RD_A;
        state_d  = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.op = OP_RD_B;
        state_d  = ST_CAP_B;
      end
      ST_CAP_B: begin
        cmd_o.op = OP_CAP_B;
        state_d  = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.op = OP_WRITE;
        pend_d   = sts_i.jobs;
        state_d  = (|sts_i.jobs) ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.op = OP_LOAD;
        if (pend_q[0]) begin
          cmd_o.job = JOB_MAIN;
          pend_d[0] = 1'b0;
        end else if (pend_q[1]) begin
          cmd_o.job = JOB_DRAIN_UP;
          pend_d[1] = 1'b0;
        end else begin
          cmd_o.job = JOB_DRAIN_LAST;
          pend_d[2] = 1'b0;
        end
        k_d     = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        if (k_q == 2'd3) begin
          state_d = ST_SQ_INIT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_SQ_INIT: begin
        cmd_o.op = OP_SQ_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (cnt_q == SQRT_CNT_W'(RES_W - 1)) begin
          state_d = ST_SCALE;
        end else begin
          cnt_d = cnt_q + SQRT_CNT_W'(1);
        end
      end
      ST_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = (|pend_q) ? ST_LOAD : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/upm_datapath.sv
// ----------------------------------------------------------------------------
// upm_datapath
// config registers, position counters, line stores, gradient/sqrt unit,
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module upm_datapath import upm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]            cfg_data_i,
  input  wire logic signed [PIX_W-1:0]     in_pix_i,
  input  wire logic [FLAG_W-1:0]           in_flag_i,
  input  wire cmd_t                        cmd_i,
  output sts_t                             sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [PIX_W-1:0]          out_pix_o,
  output logic [ROW_OUT_W-1:0]             out_row_o,
  output logic [COL_OUT_W-1:0]             out_col_o,
  output logic                             out_last_o
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [SIZE_W-1:0] rows_q, cols_q;
  logic [INV_W-1:0]  inv_row_q, inv_col_q;
  logic [TAU_W-1:0]  tau_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= ROWS_RST;
      cols_q    <= COLS_RST;
      inv_row_q <= INV_RST;
      inv_col_q <= INV_RST;
      tau_q     <= TAU_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS:    rows_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_COLS:    cols_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_INV_ROW: inv_row_q <= cfg_data_i[INV_W-1:0];
        CFG_INV_COL: inv_col_q <= cfg_data_i[INV_W-1:0];
        CFG_TAU:     tau_q     <= cfg_data_i[TAU_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes and position of the arriving pixel
  logic [RW:0]   rows_eff, r_inc;
  logic [CW:0]   cols_eff, c_inc;
  logic [RW-1:0] row_cnt_q, r_now;
  logic [CW-1:0] col_cnt_q, c_now;
  logic          row_wrap, col_wrap;

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = (RW+1)'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_eff = (RW+1)'(MAX_ROWS);
    end else begin
      rows_eff = (RW+1)'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = (CW+1)'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      cols_eff = (CW+1)'(MAX_COLS);
    end else begin
      cols_eff = (CW+1)'(cols_q);
    end
    r_now    = ({1'b0, row_cnt_q} >= rows_eff) ? '0 : row_cnt_q;
    c_now    = ({1'b0, col_cnt_q} >= cols_eff) ? '0 : col_cnt_q;
    r_inc    = {1'b0, r_now} + (RW+1)'(1);
    c_inc    = {1'b0, c_now} + (CW+1)'(1);
    row_wrap = r_inc >= rows_eff;
    col_wrap = c_inc >= cols_eff;
  end

  logic               accept;
  logic [ENTRY_W-1:0] rp0_q, rp1_q, s0_q, s1_q;

  assign accept = cmd_i.op == OP_ACCEPT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      rp0_q     <= '0;
      rp1_q     <= '0;
    end else if (accept) begin
      rp0_q <= rp1_q;
      rp1_q <= {in_flag_i, in_pix_i};
      if (row_wrap) begin
        row_cnt_q <= '0;
        col_cnt_q <= col_wrap ? '0 : c_inc[CW-1:0];
      end else begin
        row_cnt_q <= r_inc[RW-1:0];
      end
    end
  end

  // item registers
  logic signed [PIX_W-1:0] ip_q;
  logic [FLAG_W-1:0]       ifl_q;
  logic [RW-1:0]           r_q;
  logic [CW-1:0]           c_q;
  logic                    rge1_q, rge2_q, rlast_q, cge1_q, cge2_q, clast_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ip_q    <= in_pix_i;
      ifl_q   <= in_flag_i;
      r_q     <= r_now;
      c_q     <= c_now;
      s0_q    <= rp0_q;
      s1_q    <= rp1_q;
      rge1_q  <= r_now != '0;
      rge2_q  <= {1'b0, r_now} >= (RW+1)'(2);
      rlast_q <= row_wrap;
      cge1_q  <= c_now != '0;
      cge2_q  <= {1'b0, c_now} >= (CW+1)'(2);
      clast_q <= col_wrap;
    end
  end

  assign sts_o.jobs = {clast_q & rlast_q, clast_q & rge1_q, cge1_q};

  // line stores
  logic [ENTRY_W-1:0] pcs_mem [MAX_ROWS];
  logic [PIX_W-1:0]   p2s_mem [MAX_ROWS];
  logic [RW-1:0]      pcs_addr, p2s_addr;
  logic [ENTRY_W-1:0] pcs_rd_q, ce_q;
  logic [PIX_W-1:0]   p2s_rd_q;
  logic signed [PIX_W-1:0] upraw_q, dnraw_q, lfraw_q;

  always_comb begin
    if (cmd_i.op == OP_RD_B) begin
      pcs_addr = r_q + RW'(1);
      p2s_addr = r_q;
    end else begin
      pcs_addr = r_q;
      p2s_addr = r_q - RW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    pcs_rd_q <= pcs_mem[pcs_addr];
    p2s_rd_q <= p2s_mem[p2s_addr];
    if (cmd_i.op == OP_WRITE) begin
      pcs_mem[r_q] <= {ifl_q, ip_q};
      if (cge1_q) begin
        p2s_mem[r_q] <= ce_q[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RD_B) begin
      ce_q    <= pcs_rd_q;
      upraw_q <= p2s_rd_q;
    end
    if (cmd_i.op == OP_CAP_B) begin
      dnraw_q <= pcs_rd_q[PIX_W-1:0];
      lfraw_q <= p2s_rd_q;
    end
  end

  // job selection
  logic signed [PIX_W-1:0] cp, s0p, s1p;
  logic signed [PIX_W-1:0] jc_d, nb_d [4];
  logic [FLAG_W-1:0]       jfl_d;
  logic [RW-1:0]           jrow_d;
  logic [CW-1:0]           jcol_d;
  logic                    jlast_d;

  assign cp  = ce_q[PIX_W-1:0];
  assign s0p = s0_q[PIX_W-1:0];
  assign s1p = s1_q[PIX_W-1:0];

  always_comb begin
    case (cmd_i.job)
      JOB_MAIN: begin
        jc_d    = cp;
        jfl_d   = ce_q[ENTRY_W-1:PIX_W];
        nb_d[0] = rge1_q ? upraw_q : cp;
        nb_d[1] = rlast_q ? cp : dnraw_q;
        nb_d[2] = cge2_q ? lfraw_q : cp;
        nb_d[3] = ip_q;
        jrow_d  = r_q;
        jcol_d  = c_q - CW'(1);
        jlast_d = 1'b0;
      end
      JOB_DRAIN_UP: begin
        jc_d    = s1p;
        jfl_d   = s1_q[ENTRY_W-1:PIX_W];
        nb_d[0] = rge2_q ? s0p : s1p;
        nb_d[1] = ip_q;
        nb_d[2] = cge1_q ? upraw_q : s1p;
        nb_d[3] = s1p;
        jrow_d  = r_q - RW'(1);
        jcol_d  = c_q;
        jlast_d = 1'b0;
      end
      default: begin
        jc_d    = ip_q;
        jfl_d   = ifl_q;
        nb_d[0] = rge1_q ? s1p : ip_q;
        nb_d[1] = ip_q;
        nb_d[2] = cge1_q ? cp : ip_q;
        nb_d[3] = ip_q;
        jrow_d  = r_q;
        jcol_d  = c_q;
        jlast_d = 1'b1;
      end
    endcase
  end

  logic signed [PIX_W-1:0] jc_q, nb_q [4];
  logic [FLAG_W-1:0]       jfl_q;
  logic [RW-1:0]           jrow_q;
  logic [CW-1:0]           jcol_q;
  logic                    jlast_q;

  // gradient and magnitude unit
  logic signed [PIX_W:0] dif;
  logic signed [PIX_W-1:0] nsel;
  logic [INV_W-1:0]      inv_sel;
  logic [PROD_W-1:0]     prod_q;
  logic [PROD_W:0]       rnd;
  logic [G_W-1:0]        g;
  logic [SQ_W-1:0]       sq_q;
  logic [SUM_W-1:0]      sum_q, x_q, res_q, bit_q, trial;
  logic [RES_W+TAU_W-1:0] sc_prod;
  logic [RES_W+TAU_W:0]  scaled;
  logic [M_W-1:0]        m_q;

  always_comb begin
    nsel    = nb_q[cmd_i.nb];
    inv_sel = cmd_i.nb[1] ? inv_col_q : inv_row_q;
    if (jfl_q == FLAG_ERODE) begin
      dif = {jc_q[PIX_W-1], jc_q} - {nsel[PIX_W-1], nsel};
    end else begin
      dif = {nsel[PIX_W-1], nsel} - {jc_q[PIX_W-1], jc_q};
    end
    rnd     = {1'b0, prod_q} + (PROD_W+1)'(128);
    g       = rnd[PROD_W-1:8];
    trial   = res_q + bit_q;
    sc_prod = res_q[RES_W-1:0] * tau_q;
    scaled  = {1'b0, sc_prod} + (RES_W+TAU_W+1)'(32768);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        jc_q    <= jc_d;
        jfl_q   <= jfl_d;
        nb_q    <= nb_d;
        jrow_q  <= jrow_d;
        jcol_q  <= jcol_d;
        jlast_q <= jlast_d;
        sum_q   <= '0;
      end
      OP_MUL: begin
        if (!dif[PIX_W] && dif != '0) begin
          prod_q <= dif[PIX_W-1:0] * inv_sel;
        end else begin
          prod_q <= '0;
        end
      end
      OP_SQ:  sq_q  <= g * g;
      OP_ACC: sum_q <= sum_q + SUM_W'(sq_q);
      OP_SQ_INIT: begin
        x_q   <= sum_q;
        res_q <= '0;
        bit_q <= SUM_W'(1) << (SUM_W - 2);
      end
      OP_SQRT: begin
        if (x_q >= trial) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_SCALE: m_q <= scaled[RES_W+TAU_W:TAU_W];
      default: ;
    endcase
  end

  // add or subtract, saturate; other flags pass the centre pixel through
  logic signed [M_W+1:0]   upd;
  logic signed [PIX_W-1:0] res_pix;

  always_comb begin
    if (jfl_q == FLAG_ERODE) begin
      upd = (M_W+2)'(jc_q) - $signed({2'b00, m_q});
    end else begin
      upd = (M_W+2)'(jc_q) + $signed({2'b00, m_q});
    end
    if (jfl_q != FLAG_ERODE && jfl_q != FLAG_DILATE) begin
      res_pix = jc_q;
    end else if (upd[M_W+1] && !(&upd[M_W+1:PIX_W-1])) begin
      res_pix = {1'b1, {(PIX_W-1){1'b0}}};
    end else if (!upd[M_W+1] && (|upd[M_W+1:PIX_W-1])) begin
      res_pix = {1'b0, {(PIX_W-1){1'b1}}};
    end else begin
      res_pix = upd[PIX_W-1:0];
    end
  end

  // output register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_pix_o  <= res_pix;
      out_row_o  <= ROW_OUT_W'(jrow_q);
      out_col_o  <= COL_OUT_W'(jcol_q);
      out_last_o <= jlast_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/upwind_morphological_pde_step_top.sv
// ----------------------------------------------------------------------------
// upwind_morphological_pde_step_top
// one explicit upwind erosion/dilation step on a column-major pixel stream
// ----------------------------------------------------------------------------
// channel   dir  tdata / data                         tuser / tlast
// s_axis    in   [15:0] pixel_value                   tuser [1:0] sign_flag
// m_axis    out  [15:0] result_pixel, [24:16] out_row, tlast last_of_image
//                [33:25] out_col, [39:34] zero
// cfg       in   cfg_idx_i selects, cfg_data_i value  -
//
// a pixel takes line store reads and writes, then 0 to 3 results, each set by
// the 4-pass gradient multiplier and the 25-step square root; the next pixel
// is taken once the last result sits in the output register, or after the
// write when the pixel gives no result
// a full output register holds the sequencer before it emits the next result
// reset clears counters and recent pixels; line stores need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module upwind_morphological_pde_step_top import upm_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,   // pixel_value
  input  wire logic [TUSER_IN_W-1:0]  s_axis_tuser,   // sign_flag
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,   // result_pixel, out_row, out_col
  output logic                        m_axis_tlast    // last_of_image
);

  cmd_t                    cmd;
  sts_t                    sts;
  logic signed [PIX_W-1:0] out_pix;
  logic [ROW_OUT_W-1:0]    out_row;
  logic [COL_OUT_W-1:0]    out_col;

  upm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  upm_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_pix_i    (s_axis_tdata[PIX_W-1:0]),
    .in_flag_i   (s_axis_tuser[FLAG_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {(TDATA_OUT_W - OUT_BITS)'(0), out_col, out_row, out_pix};

endmodule

`default_nettype wire
